### rtl/core/dtps_pkg.sv
// Package for the third-point search: datapath widths and the control word
// of the shared multiply-accumulate unit. No dependencies.
package dtps_pkg;

  // Field and datapath widths
  localparam int FIELD_W = 15;               // coordinate field on the ports
  localparam int DIFF_W  = 16;               // coordinate difference
  localparam int OPA_W   = 34;               // wide multiplier operand
  localparam int OPB_W   = 17;               // narrow multiplier operand
  localparam int PROD_W  = OPA_W + OPB_W;    // full product
  localparam int ACC_W   = 66;               // accumulator, holds a cross product
  localparam int NUM_W   = 33;               // numerator, signed
  localparam int DEN_W   = 32;               // denominator, always positive
  localparam int HALF_W  = 16;               // split of the denominator
  localparam int PT_W    = 2 * FIELD_W;      // packed x,y entry

  // Accumulator control for the product registered in the previous cycle
  typedef struct packed {
    logic en;    // update the accumulator
    logic load;  // start a new sum with the product
    logic sub;   // subtract instead of add
    logic hi;    // product weighted by 2^HALF_W
  } dtps_acc_ctrl_t;

endpackage

### rtl/core/dtps_in_if.sv
// Request channel carrying one candidate point and its edge.
// Depends on dtps_pkg for the field width.
interface dtps_in_if;
  import dtps_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] edge_start_x;
  logic signed [FIELD_W-1:0] edge_start_y;
  logic signed [FIELD_W-1:0] edge_end_x;
  logic signed [FIELD_W-1:0] edge_end_y;
  logic signed [FIELD_W-1:0] point_x;
  logic signed [FIELD_W-1:0] point_y;
  logic                      final_point;

  modport source (
    output valid, edge_start_x, edge_start_y, edge_end_x, edge_end_y,
           point_x, point_y, final_point,
    input  ready
  );

  modport sink (
    input  valid, edge_start_x, edge_start_y, edge_end_x, edge_end_y,
           point_x, point_y, final_point,
    output ready
  );

endinterface

### rtl/core/dtps_out_if.sv
// Result channel carrying one best or tied point of a search.
// Depends on dtps_pkg for the field width.
interface dtps_out_if;
  import dtps_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      found;
  logic signed [FIELD_W-1:0] cand_x;
  logic signed [FIELD_W-1:0] cand_y;
  logic                      end_of_run;
  logic                      tie_overflow;

  modport source (
    output valid, found, cand_x, cand_y, end_of_run, tie_overflow,
    input  ready
  );

  modport sink (
    input  valid, found, cand_x, cand_y, end_of_run, tie_overflow,
    output ready
  );

endinterface

### rtl/core/dtps_mac.sv
// Shared multiply-accumulate unit: one signed multiplier with a registered
// product, followed by a wide accumulator. Depends on dtps_pkg.
module dtps_mac
  import dtps_pkg::*;
(
  input  logic                     clk,
  input  logic signed [OPA_W-1:0]  op_a,
  input  logic signed [OPB_W-1:0]  op_b,
  input  dtps_acc_ctrl_t           ctrl,
  output logic signed [ACC_W-1:0]  acc
);

  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  term;

  // Weight the product, then load, add or subtract
  always_comb begin
    prod_ext = ACC_W'(prod_r);
    term     = ctrl.hi ? (prod_ext <<< HALF_W) : prod_ext;
    if (ctrl.load) begin
      acc_nxt = term;
    end else if (ctrl.sub) begin
      acc_nxt = acc_r - term;
    end else begin
      acc_nxt = acc_r + term;
    end
  end

  // Product register and accumulator
  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
    if (ctrl.en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

### rtl/core/delaunay_third_point_search.sv
// Third-point search for growing an edge of a triangulation.
// Input channel in_if: one candidate point per request, tagged with the
// directed edge S->E being grown; final_point marks the last point of a
// search. Points not strictly left of the edge are skipped. Of the rest the
// block keeps those with the largest ratio of numerator (dot product of the
// two side vectors) to denominator (edge cross product), compared exactly by
// cross-multiplication in one shared 34x17 multiplier and accumulator.
// Flow: a request is taken only in idle, so points are searched one at a
// time. A skipped point, or the first qualifying point of a search, ends at
// the decision on the denominator; any other point runs all the steps
// (eight products through the shared multiplier plus the compare).
// After the final point each buffered point is sent as one result, read
// from the tie buffer and held until out_if.ready; an empty search gives a
// single result with found low. The last result carries end_of_run.
// A stalled receiver holds the result register; no new request is taken
// until the last result has gone. Ties beyond TIE_DEPTH are dropped and
// tie_overflow is raised on every result of that search.
// Reset (rst_n low, synchronous) returns to idle with an empty search.
// Depends on dtps_pkg, dtps_in_if, dtps_out_if and dtps_mac.
module delaunay_third_point_search
  import dtps_pkg::*;
#(
  parameter int TIE_DEPTH  = 16,
  parameter int COORD_BITS = 15
) (
  input  logic       clk,
  input  logic       rst_n,
  dtps_in_if.sink    in_if,
  dtps_out_if.source out_if
);

  localparam int CNT_W = $clog2(TIE_DEPTH + 1);
  localparam int IDX_W = (TIE_DEPTH > 1) ? $clog2(TIE_DEPTH) : 1;

  // Sequencer steps within one point
  localparam logic [3:0] S_N0  = 4'd0;  // issue (Px-Ex)*(Sx-Px)
  localparam logic [3:0] S_N1  = 4'd1;  // issue (Py-Ey)*(Sy-Py)
  localparam logic [3:0] S_D0  = 4'd2;  // issue (Ex-Sx)*(Py-Sy)
  localparam logic [3:0] S_D1  = 4'd3;  // issue (Ey-Sy)*(Px-Sx), capture N
  localparam logic [3:0] S_L0  = 4'd4;  // issue N*best_denom low half
  localparam logic [3:0] S_DEC = 4'd5;  // D ready: skip or first best
  localparam logic [3:0] S_R0  = 4'd6;  // issue best_numer*D low half
  localparam logic [3:0] S_R1  = 4'd7;  // capture left side of compare
  localparam logic [3:0] S_ACC = 4'd8;  // last accumulate
  localparam logic [3:0] S_CMP = 4'd9;  // compare and update

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FETCH,
    ST_SHOW
  } state_t;

  state_t                    state_r;
  logic [3:0]                step_r;
  logic                      final_r;
  logic signed [DIFF_W-1:0]  px_r, py_r;
  logic signed [DIFF_W-1:0]  d_pe_x_r, d_sp_x_r, d_pe_y_r, d_sp_y_r;
  logic signed [DIFF_W-1:0]  d_es_x_r, d_ps_y_r, d_es_y_r, d_ps_x_r;
  logic signed [NUM_W-1:0]   n_r;
  logic [DEN_W-1:0]          d_r;
  logic signed [ACC_W-1:0]   lhs_r;
  logic signed [NUM_W-1:0]   best_numer_r;
  logic [DEN_W-1:0]          best_denom_r;
  logic                      have_best_r;
  logic [CNT_W-1:0]          tie_count_r;
  logic                      ovf_r;
  logic [IDX_W-1:0]          rd_idx_r;
  logic                      found_r;
  logic                      eor_r;
  logic                      tovf_r;
  logic [PT_W-1:0]           rd_data_r;

  logic [PT_W-1:0]           tie_mem [TIE_DEPTH];

  logic signed [DIFF_W-1:0]  sx, sy, ex, ey, px, py;
  logic signed [OPA_W-1:0]   op_a;
  logic signed [OPB_W-1:0]   op_b;
  dtps_acc_ctrl_t            acc_ctrl;
  logic signed [ACC_W-1:0]   acc;
  logic                      take_best;
  logic                      take_tie;
  logic                      finish;
  logic                      buf_full;
  logic                      mem_we;
  logic [IDX_W-1:0]          mem_addr;
  logic [DEN_W-1:0]          new_denom;
  logic                      last_res;

  // Coordinates read from their low COORD_BITS bits, sign-extended
  assign sx = DIFF_W'($signed(in_if.edge_start_x[COORD_BITS-1:0]));
  assign sy = DIFF_W'($signed(in_if.edge_start_y[COORD_BITS-1:0]));
  assign ex = DIFF_W'($signed(in_if.edge_end_x[COORD_BITS-1:0]));
  assign ey = DIFF_W'($signed(in_if.edge_end_y[COORD_BITS-1:0]));
  assign px = DIFF_W'($signed(in_if.point_x[COORD_BITS-1:0]));
  assign py = DIFF_W'($signed(in_if.point_y[COORD_BITS-1:0]));

  // Operand selection for the shared multiplier
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (step_r)
      S_N0: begin
        op_a = OPA_W'(d_pe_x_r);
        op_b = OPB_W'(d_sp_x_r);
      end
      S_N1: begin
        op_a = OPA_W'(d_pe_y_r);
        op_b = OPB_W'(d_sp_y_r);
      end
      S_D0: begin
        op_a = OPA_W'(d_es_x_r);
        op_b = OPB_W'(d_ps_y_r);
      end
      S_D1: begin
        op_a = OPA_W'(d_es_y_r);
        op_b = OPB_W'(d_ps_x_r);
      end
      S_L0: begin
        op_a = OPA_W'(n_r);
        op_b = {1'b0, best_denom_r[HALF_W-1:0]};
      end
      S_DEC: begin
        op_a = OPA_W'(n_r);
        op_b = {1'b0, best_denom_r[DEN_W-1:HALF_W]};
      end
      S_R0: begin
        op_a = OPA_W'(best_numer_r);
        op_b = {1'b0, d_r[HALF_W-1:0]};
      end
      S_R1: begin
        op_a = OPA_W'(best_numer_r);
        op_b = {1'b0, d_r[DEN_W-1:HALF_W]};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // Accumulator control, one step behind the operands
  always_comb begin
    acc_ctrl = '0;
    if (state_r == ST_RUN) begin
      case (step_r)
        S_N1:    acc_ctrl = '{en: 1'b1, load: 1'b1, sub: 1'b0, hi: 1'b0};
        S_D0:    acc_ctrl = '{en: 1'b1, load: 1'b0, sub: 1'b0, hi: 1'b0};
        S_D1:    acc_ctrl = '{en: 1'b1, load: 1'b1, sub: 1'b0, hi: 1'b0};
        S_L0:    acc_ctrl = '{en: 1'b1, load: 1'b0, sub: 1'b1, hi: 1'b0};
        S_DEC:   acc_ctrl = '{en: 1'b1, load: 1'b1, sub: 1'b0, hi: 1'b0};
        S_R0:    acc_ctrl = '{en: 1'b1, load: 1'b0, sub: 1'b0, hi: 1'b1};
        S_R1:    acc_ctrl = '{en: 1'b1, load: 1'b1, sub: 1'b0, hi: 1'b0};
        S_ACC:   acc_ctrl = '{en: 1'b1, load: 1'b0, sub: 1'b0, hi: 1'b1};
        default: acc_ctrl = '0;
      endcase
    end
  end

  dtps_mac u_mac (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .ctrl (acc_ctrl),
    .acc  (acc)
  );

  // Decisions: skip, new best or tie
  always_comb begin
    take_best = 1'b0;
    take_tie  = 1'b0;
    finish    = 1'b0;
    new_denom = d_r;
    if (state_r == ST_RUN) begin
      if (step_r == S_DEC) begin
        new_denom = acc[DEN_W-1:0];
        if (!(acc > 0)) begin
          finish = 1'b1;
        end else if (!have_best_r) begin
          take_best = 1'b1;
          finish    = 1'b1;
        end
      end else if (step_r == S_CMP) begin
        finish = 1'b1;
        if (lhs_r > acc) begin
          take_best = 1'b1;
        end else if (lhs_r == acc) begin
          take_tie = 1'b1;
        end
      end
    end
  end

  assign buf_full = (tie_count_r >= CNT_W'(TIE_DEPTH));
  assign mem_we   = take_best || (take_tie && !buf_full);
  assign mem_addr = take_best ? '0 : tie_count_r[IDX_W-1:0];
  assign last_res = !have_best_r || ((CNT_W'(rd_idx_r) + 1'b1) == tie_count_r);

  // Tie buffer with registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      tie_mem[mem_addr] <= {px_r[FIELD_W-1:0], py_r[FIELD_W-1:0]};
    end
    if (state_r == ST_FETCH) begin
      rd_data_r <= tie_mem[rd_idx_r];
    end
  end

  // Sequencer, search state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      step_r       <= S_N0;
      have_best_r  <= 1'b0;
      tie_count_r  <= '0;
      ovf_r        <= 1'b0;
      best_numer_r <= '0;
      best_denom_r <= '0;
      rd_idx_r     <= '0;
      found_r      <= 1'b0;
      eor_r        <= 1'b0;
      tovf_r       <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_if.valid) begin
            px_r     <= px;
            py_r     <= py;
            final_r  <= in_if.final_point;
            d_pe_x_r <= px - ex;
            d_sp_x_r <= sx - px;
            d_pe_y_r <= py - ey;
            d_sp_y_r <= sy - py;
            d_es_x_r <= ex - sx;
            d_ps_y_r <= py - sy;
            d_es_y_r <= ey - sy;
            d_ps_x_r <= px - sx;
            step_r   <= S_N0;
            state_r  <= ST_RUN;
          end
        end
        ST_RUN: begin
          step_r <= step_r + 4'd1;
          if (step_r == S_D1) begin
            n_r <= acc[NUM_W-1:0];
          end
          if (step_r == S_DEC) begin
            d_r <= acc[DEN_W-1:0];
          end
          if (step_r == S_R1) begin
            lhs_r <= acc;
          end
          if (take_best) begin
            have_best_r  <= 1'b1;
            best_numer_r <= n_r;
            best_denom_r <= new_denom;
            tie_count_r  <= CNT_W'(1);
            ovf_r        <= 1'b0;
          end else if (take_tie) begin
            if (buf_full) begin
              ovf_r <= 1'b1;
            end else begin
              tie_count_r <= tie_count_r + 1'b1;
            end
          end
          if (finish) begin
            rd_idx_r <= '0;
            state_r  <= final_r ? ST_FETCH : ST_IDLE;
          end
        end
        ST_FETCH: begin
          found_r <= have_best_r;
          eor_r   <= last_res;
          tovf_r  <= have_best_r && ovf_r;
          state_r <= ST_SHOW;
        end
        ST_SHOW: begin
          if (out_if.ready) begin
            if (eor_r) begin
              have_best_r  <= 1'b0;
              tie_count_r  <= '0;
              ovf_r        <= 1'b0;
              best_numer_r <= '0;
              best_denom_r <= '0;
              state_r      <= ST_IDLE;
            end else begin
              rd_idx_r <= rd_idx_r + 1'b1;
              state_r  <= ST_FETCH;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Channel outputs
  assign in_if.ready         = (state_r == ST_IDLE);
  assign out_if.valid        = (state_r == ST_SHOW);
  assign out_if.found        = found_r;
  assign out_if.cand_x       = found_r ? rd_data_r[PT_W-1:FIELD_W] : '0;
  assign out_if.cand_y       = found_r ? rd_data_r[FIELD_W-1:0] : '0;
  assign out_if.end_of_run   = eor_r;
  assign out_if.tie_overflow = tovf_r;

endmodule
